// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the core RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/avm_pkg.sv =====
// ---------------------------------------------------------------------------
// avm_pkg
// Constants and codes of the approximate vector magnitude unit.
// ---------------------------------------------------------------------------
`default_nettype none

package avm_pkg;

  localparam int COORD_BITS = 32;
  localparam int MAG_BITS   = COORD_BITS + 1;
  localparam int DATA_BITS  = 32;
  localparam int PADDR_BITS = 3;
  localparam int MODE_BITS  = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] abs_t;
  typedef logic        [MAG_BITS-1:0]   mag_t;
  typedef logic        [MODE_BITS-1:0]  mode_t;

  localparam mode_t MODE_L1       = 3'd0;
  localparam mode_t MODE_APPROX13 = 3'd1;
  localparam mode_t MODE_APPROX9  = 3'd2;
  localparam mode_t MODE_APPROX8  = 3'd3;
  localparam mode_t MODE_HALF_MIN = 3'd4;
  localparam mode_t MODE_FINE_2D  = 3'd5;

  localparam mode_t MODE_RESET = MODE_APPROX8;

  // register index, taken from paddr[2]
  localparam logic REG_NORM_MODE = 1'b0;

  function automatic abs_t abs_coord(input coord_t v);
    abs_t r;
    r = v[COORD_BITS-1] ? abs_t'(~v + 1'b1) : abs_t'(v);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/approx_vector_magnitude_unit.sv =====
// ---------------------------------------------------------------------------
// approx_vector_magnitude_unit
// Approximate length of a signed 16.16 vector by shift-add formulas.
// ---------------------------------------------------------------------------
// Input channel: x_in, y_in, z_in with in_valid/in_stall; output channel:
// magnitude (unsigned 17.16) with out_valid/out_stall. A transfer happens
// at a clock edge with valid high and stall low.
// norm_mode (APB, byte address 0) selects the formula; write it only
// while the unit is empty. Codes 6 and 7 give a magnitude of zero.
// Four register stages: absolute value, sort, shifted partial sums,
// final add into the output register; one transfer per cycle sustained
// while out_stall is low.
// Each stage loads when empty or when the stage after it moves on, so
// bubbles fill while the output is stalled; in_stall rises only when all
// four stages hold data and out_stall is high. Nothing is dropped or
// duplicated under stall.
// Reset (rst, synchronous) empties the pipeline and sets norm_mode to 3.
// ---------------------------------------------------------------------------
`default_nettype none

module approx_vector_magnitude_unit (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [avm_pkg::PADDR_BITS-1:0]   paddr,
  input  wire  [avm_pkg::DATA_BITS-1:0]    pwdata,
  output logic [avm_pkg::DATA_BITS-1:0]    prdata,
  output logic                             pready,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [avm_pkg::COORD_BITS-1:0]   x_in,
  input  wire  [avm_pkg::COORD_BITS-1:0]   y_in,
  input  wire  [avm_pkg::COORD_BITS-1:0]   z_in,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [avm_pkg::MAG_BITS-1:0]     magnitude
);
  import avm_pkg::*;

  `include "assert_macros.svh"

  mode_t norm_mode;

  logic  s1_valid, s2_valid, s3_valid;
  logic  ld1, ld2, ld3, ld_out;

  abs_t  s1_ax, s1_ay, s1_az;
  mode_t s1_mode;

  abs_t  s2_a, s2_b, s2_c;
  mode_t s2_mode;

  mag_t  s3_pa, s3_pb;

  abs_t  hi, mid, lo, hi2, lo2;
  abs_t  a_next, b_next, c_next;
  mag_t  pa_next, pb_next;
  mag_t  ea, eb, ec;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_mode <= MODE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_NORM_MODE) begin
      norm_mode <= pwdata[MODE_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_NORM_MODE) begin
      prdata = {{(DATA_BITS-MODE_BITS){1'b0}}, norm_mode};
    end
  end

  // stage advance
  assign ld_out   = !out_valid || !out_stall;
  assign ld3      = !s3_valid || ld_out;
  assign ld2      = !s2_valid || ld3;
  assign ld1      = !s1_valid || ld2;
  assign in_stall = !ld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ld1)    s1_valid  <= in_valid;
      if (ld2)    s2_valid  <= s1_valid;
      if (ld3)    s3_valid  <= s2_valid;
      if (ld_out) out_valid <= s3_valid;
    end
  end

  // stage 2: sort by value (x and y only in the 2D modes)
  always_comb begin
    hi  = (s1_ax >= s1_ay && s1_ax >= s1_az) ? s1_ax : ((s1_ay >= s1_az) ? s1_ay : s1_az);
    lo  = (s1_ax <= s1_ay && s1_ax <= s1_az) ? s1_ax : ((s1_ay <= s1_az) ? s1_ay : s1_az);
    mid = s1_ax ^ s1_ay ^ s1_az ^ hi ^ lo;
    hi2 = (s1_ax < s1_ay) ? s1_ay : s1_ax;
    lo2 = (s1_ax < s1_ay) ? s1_ax : s1_ay;
    if (s1_mode == MODE_HALF_MIN || s1_mode == MODE_FINE_2D) begin
      a_next = hi2;
      b_next = lo2;
      c_next = '0;
    end else begin
      a_next = hi;
      b_next = mid;
      c_next = lo;
    end
  end

  // stage 3: shifted partial sums
  assign ea = {1'b0, s2_a};
  assign eb = {1'b0, s2_b};
  assign ec = {1'b0, s2_c};

  always_comb begin
    pa_next = '0;
    pb_next = '0;
    case (s2_mode)
      MODE_L1: begin
        pa_next = ea + ec;
        pb_next = eb;
      end
      MODE_APPROX13: begin
        pa_next = ea;
        pb_next = (eb + ec) >> 2;
      end
      MODE_APPROX9: begin
        pa_next = ea + (ec >> 2);
        pb_next = (eb >> 2) + (eb >> 4);
      end
      MODE_APPROX8: begin
        pa_next = ea + (ec >> 2);
        pb_next = (eb >> 2) + (eb >> 4) + (eb >> 5);
      end
      MODE_HALF_MIN: begin
        pa_next = ea;
        pb_next = eb >> 1;
      end
      MODE_FINE_2D: begin
        pa_next = ea - (ea >> 5) - (ea >> 7);
        pb_next = (eb >> 1) - (eb >> 4) - (eb >> 5) - (eb >> 7);
      end
      default: begin
        pa_next = '0;
        pb_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld1 && in_valid) begin
      s1_ax   <= abs_coord(x_in);
      s1_ay   <= abs_coord(y_in);
      s1_az   <= abs_coord(z_in);
      s1_mode <= norm_mode;
    end
    if (ld2 && s1_valid) begin
      s2_a    <= a_next;
      s2_b    <= b_next;
      s2_c    <= c_next;
      s2_mode <= s1_mode;
    end
    if (ld3 && s2_valid) begin
      s3_pa <= pa_next;
      s3_pb <= pb_next;
    end
    if (ld_out && s3_valid) begin
      magnitude <= s3_pa + s3_pb;
    end
  end

  `ASSERT_NEXT(a_in_lands, clk, rst, in_valid && !in_stall, s1_valid)
  `ASSERT_IMPL(a_stall_full, clk, rst, in_stall, s1_valid && s2_valid && s3_valid && out_valid)
  `ASSERT_NEXT(a_out_load, clk, rst, s3_valid && ld_out, out_valid)
  `ASSERT_IMPL(a_sorted, clk, rst, s2_valid, s2_a >= s2_b && s2_b >= s2_c)

endmodule

`default_nettype wire
